// ===== rtl/serial_frame_checker_unit_macros.svh =====
// Assertion helpers for the serial frame checker.
`ifndef SERIAL_FRAME_CHECKER_UNIT_MACROS_SVH
`define SERIAL_FRAME_CHECKER_UNIT_MACROS_SVH

// Checked on aclk, masked while aresetn is low.
`define SFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on aclk at every edge, reset included.
`define SFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/sfc_pkg.sv =====
`timescale 1ns / 1ps
package sfc_pkg;

    localparam logic [7:0] ACK_BYTE       = 8'h06;
    localparam logic [7:0] NACK_BYTE      = 8'h0A;
    localparam logic [7:0] MARKER_BYTE    = 8'h24;   // '$'
    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
    localparam logic [7:0] COUNT_MAX      = 8'd255;

    // Byte positions inside the frame header.
    localparam logic [7:0] POS_LENGTH  = 8'd1;
    localparam logic [7:0] POS_MARKER  = 8'd2;
    localparam logic [7:0] POS_PAYLOAD = 8'd3;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_SIZE = 2'd1,
        ST_BAD  = 2'd2
    } sfc_status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } sfc_kind_t;

    // Packed so that payload_byte lands in the lowest bits.
    typedef struct packed {
        logic [7:0]  payload_length;
        logic [7:0]  device_code;
        logic        deliver;
        logic [7:0]  response_byte;
        logic        send_response;
        sfc_status_t status;
        logic [7:0]  payload_byte;
    } sfc_result_t;

    function automatic logic [7:0] port_letter(input logic [1:0] port);
        logic [7:0] code;
        case (port)
            2'd0:    code = 8'h41;  // 'A'
            2'd1:    code = 8'h42;  // 'B'
            2'd2:    code = 8'h20;  // ' '
            default: code = 8'h43;  // 'C'
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/serial_frame_checker_unit.sv =====
`timescale 1ns / 1ps
// Serial frame checker.
// Input stream (s_*): one received byte per word, s_tlast on the final
// byte of a frame, s_tuser carries the serial port the frame came from.
// Frame layout: start byte, length L, '$', L payload bytes, checksum low,
// checksum high. Checksum is the 16-bit wrapping sum of L, '$' and payload.
// Output stream (m_*): each payload byte is forwarded as a tentative word
// (m_tuser = 0); the last byte yields a verdict word (m_tuser = 1) with
// status, ACK/NACK response and the deliver flag. Other bytes give no word.
// Latency: m_tvalid rises in the cycle after input accept. Throughput: one
// byte per cycle while the output slot is free; the frame state updates
// through counter, add and compare logic, and the output register takes a
// new word in the same cycle the old one leaves.
// Stall: s_tready drops only while a result waits and m_tready is low;
// bytes that produce no word still need that slot free.
// Reset (aresetn low, synchronous): frame state cleared, output empty,
// rx_enable cleared. cfg_wr_en writes rx_enable; write only while idle.
module serial_frame_checker_unit
    import sfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_wr_data,   // rx_enable

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  logic        s_tlast,       // last_byte
    input  logic [1:0]  s_tuser,       // [1:0] source_port

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [9:8] status, [10] send_response,
    // [18:11] response_byte, [19] deliver, [27:20] device_code,
    // [35:28] payload_length, [39:36] zero
    output logic [39:0] m_tdata,
    output logic [0:0]  m_tuser        // [0] kind
);

`include "serial_frame_checker_unit_macros.svh"

    // Frame state.
    logic        rx_enable_reg;
    logic [7:0]  byte_count_reg,  byte_count_next;
    logic [7:0]  decl_len_reg,    decl_len_next;
    logic [15:0] sum_acc_reg,     sum_acc_next;
    logic        marker_seen_reg, marker_seen_next;
    logic [7:0]  check_low_reg,   check_low_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    sfc_result_t result_reg;
    sfc_kind_t   kind_reg;

    // Combinational result for the word at the input.
    logic        res_valid;
    sfc_result_t res;
    sfc_kind_t   res_kind;

    logic        s_accept;
    logic        saturated;
    logic        in_payload;
    logic [8:0]  pay_end;     // L + 3, up to 258
    logic [8:0]  frame_total; // L + 5
    logic [8:0]  pos_plus1;
    logic [15:0] rx_sum;

    // Slot is free when empty or when its word leaves this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        // Length byte is taken the same cycle it arrives.
        decl_len_next = (byte_count_reg == POS_LENGTH) ? s_tdata : decl_len_reg;

        saturated   = (byte_count_reg == COUNT_MAX);
        pay_end     = {1'b0, decl_len_next} + {1'b0, POS_PAYLOAD};
        frame_total = {1'b0, decl_len_next} + FRAME_OVERHEAD;
        pos_plus1   = {1'b0, byte_count_reg} + 9'd1;
        in_payload  = !saturated && (byte_count_reg >= POS_PAYLOAD)
                      && ({1'b0, byte_count_reg} < pay_end);
        rx_sum      = {s_tdata, check_low_reg};

        sum_acc_next = sum_acc_reg;
        if ((byte_count_reg == POS_LENGTH) || (byte_count_reg == POS_MARKER) || in_payload) begin
            sum_acc_next = sum_acc_reg + {8'd0, s_tdata};
        end

        marker_seen_next = marker_seen_reg;
        if (byte_count_reg == POS_MARKER) begin
            marker_seen_next = (s_tdata == MARKER_BYTE);
        end

        check_low_next = check_low_reg;
        if (!saturated && ({1'b0, byte_count_reg} == pay_end)) begin
            check_low_next = s_tdata;
        end

        byte_count_next = saturated ? byte_count_reg : pos_plus1[7:0];

        res                = '0;
        res.device_code    = port_letter(s_tuser);
        res.payload_length = decl_len_next;
        res_kind           = KIND_PAYLOAD;
        res_valid          = 1'b0;

        if (!s_tlast) begin
            res_valid        = in_payload;
            res.payload_byte = s_tdata;
        end else begin
            res_valid = 1'b1;
            res_kind  = KIND_VERDICT;
            // Count is one short of the frame size before this byte.
            if (saturated || (byte_count_reg == 8'd0) || (pos_plus1 != frame_total)) begin
                res.status = ST_SIZE;
            end else if ((rx_sum == sum_acc_reg) && marker_seen_reg) begin
                res.status        = ST_GOOD;
                res.send_response = 1'b1;
                res.response_byte = ACK_BYTE;
                res.deliver       = rx_enable_reg;
            end else begin
                res.status        = ST_BAD;
                res.send_response = 1'b1;
                res.response_byte = NACK_BYTE;
            end
            // Any verdict ends the frame.
            byte_count_next  = 8'd0;
            decl_len_next    = 8'd0;
            sum_acc_next     = 16'd0;
            marker_seen_next = 1'b0;
            check_low_next   = 8'd0;
        end

        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = res_valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_enable_reg   <= 1'b0;
            byte_count_reg  <= 8'd0;
            decl_len_reg    <= 8'd0;
            sum_acc_reg     <= 16'd0;
            marker_seen_reg <= 1'b0;
            check_low_reg   <= 8'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rx_enable_reg <= cfg_wr_data[0];
            end
            if (s_accept) begin
                byte_count_reg  <= byte_count_next;
                decl_len_reg    <= decl_len_next;
                sum_acc_reg     <= sum_acc_next;
                marker_seen_reg <= marker_seen_next;
                check_low_reg   <= check_low_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload side of the output register, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            result_reg <= res;
            kind_reg   <= res_kind;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {4'd0, result_reg};
    assign m_tuser[0] = kind_reg;

    // Saturated counter stays put until the frame ends.
    `SFC_ASSERT(a_count_sat, s_accept && !s_tlast && (byte_count_reg == COUNT_MAX) |=> (byte_count_reg == COUNT_MAX), "byte counter left saturation mid-frame")
    // Last byte always restarts the frame.
    `SFC_ASSERT(a_frame_clear, s_accept && s_tlast |=> (byte_count_reg == 8'd0) && (sum_acc_reg == 16'd0), "frame state not cleared after verdict")
    // Delivery only on an acknowledged verdict.
    `SFC_ASSERT(a_deliver_ack, m_valid_reg && result_reg.deliver |-> (kind_reg == KIND_VERDICT) && (result_reg.status == ST_GOOD) && (result_reg.response_byte == ACK_BYTE), "deliver without ACK verdict")
    // Responses are ACK or NACK, never on a size error.
    `SFC_ASSERT(a_resp_code, m_valid_reg && result_reg.send_response |-> ((result_reg.response_byte == ACK_BYTE) || (result_reg.response_byte == NACK_BYTE)) && (result_reg.status != ST_SIZE), "bad response code")
    // A word with no new input and no pop keeps its slot.
    `SFC_ASSERT(a_no_drop, m_valid_reg && !m_tready |=> m_valid_reg, "pending result lost")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import sfc_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 10;

    localparam logic [7:0] PORT_CODES [4] = '{8'h41, 8'h42, 8'h20, 8'h43};

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_MARKER,
        FR_TRUNCATED,
        FR_OVERRUN,
        FR_NOISE
    } frame_flavor_t;

    typedef struct packed {
        sfc_kind_t   kind;
        sfc_result_t word;
    } frame_word_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [0:0]  cfg_wr_data = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'h00;
    logic        s_tlast     = 1'b0;
    logic [1:0]  s_tuser     = 2'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b1;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    serial_frame_checker_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Shadow of the checker's frame state
    logic [7:0]  frame_pos;
    logic [7:0]  frame_len;
    logic [15:0] frame_sum;
    logic        marker_ok;
    logic [7:0]  chk_lo;
    logic        rx_en_shadow;

    frame_word_t pending_words[$];
    logic [7:0]  frame_bytes[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    bit          src_idle_on = 1'b0;
    bit          sink_stalls_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance the frame state by one byte; returns the word it causes, if any.
    function automatic void predict_rx_byte(input logic [7:0] rx, input logic last,
                                            input logic [1:0] port,
                                            output bit produced, output frame_word_t w);
        logic [7:0]  pos;
        logic [8:0]  len9;
        logic        sat;
        logic        in_pay;
        logic [15:0] rx_sum;
        pos = frame_pos;
        sat = (pos == COUNT_MAX);
        if (pos == POS_LENGTH)
            frame_len = rx;
        len9 = {1'b0, frame_len};
        in_pay = !sat && pos >= POS_PAYLOAD && {1'b0, pos} < len9 + 9'd3;
        if (pos == POS_LENGTH || pos == POS_MARKER || in_pay)
            frame_sum = frame_sum + {8'h00, rx};
        if (pos == POS_MARKER)
            marker_ok = (rx == MARKER_BYTE);
        if (!sat && {1'b0, pos} == len9 + 9'd3)
            chk_lo = rx;
        if (!sat)
            frame_pos = pos + 8'd1;

        w = '0;
        w.word.device_code    = PORT_CODES[port];
        w.word.payload_length = frame_len;
        produced = 1'b1;
        if (!last) begin
            produced = in_pay;
            w.kind = KIND_PAYLOAD;
            w.word.payload_byte = rx;
            w.word.status = ST_GOOD;
            return;
        end

        w.kind = KIND_VERDICT;
        if (sat || pos == 8'd0 || {1'b0, pos} + 9'd1 != len9 + FRAME_OVERHEAD) begin
            w.word.status = ST_SIZE;
        end else begin
            rx_sum = {rx, chk_lo};
            w.word.send_response = 1'b1;
            if (rx_sum == frame_sum && marker_ok) begin
                w.word.status        = ST_GOOD;
                w.word.response_byte = ACK_BYTE;
                w.word.deliver       = rx_en_shadow;
            end else begin
                w.word.status        = ST_BAD;
                w.word.response_byte = NACK_BYTE;
            end
        end
        frame_pos = 8'd0;
        frame_len = 8'd0;
        frame_sum = 16'd0;
        marker_ok = 1'b0;
        chk_lo    = 8'd0;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got_v,
                                   input logic [39:0] want_v);
        $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got_v, want_v);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [7:0] data, input logic last, input logic [1:0] port);
        bit          produced;
        frame_word_t w;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        s_tuser  <= port;
        do @(posedge aclk); while (!s_tready);
        predict_rx_byte(data, last, port, produced, w);
        if (produced)
            pending_words.push_back(w);
        words_sent++;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sends frame_bytes, tlast on the final byte; mix_ports gives every byte a random port.
    task automatic send_frame(input logic [1:0] port, input bit mix_ports);
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_word(frame_bytes[i], i == frame_bytes.size() - 1,
                      mix_ports ? 2'($urandom_range(0, 3)) : port);
    endtask

    // Waits for the output to drain, then lets the last byte settle before the write.
    task automatic set_rx_enable(input logic value);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        rx_en_shadow = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic build_frame(input int len, input frame_flavor_t flavor);
        logic [15:0] sum;
        logic [7:0]  marker;
        logic [7:0]  b;
        int          k;
        frame_bytes.delete();
        if (flavor == FR_NOISE) begin
            repeat ($urandom_range(1, 8))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        marker = MARKER_BYTE;
        if (flavor == FR_BAD_MARKER)
            do marker = 8'($urandom_range(0, 255)); while (marker == MARKER_BYTE);
        frame_bytes.push_back(8'($urandom_range(0, 255)));  // start byte, never checked
        frame_bytes.push_back(8'(len));
        frame_bytes.push_back(marker);
        sum = 16'(len) + {8'h00, marker};
        for (k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            frame_bytes.push_back(b);
            sum = sum + {8'h00, b};
        end
        if (flavor == FR_BAD_SUM)
            sum = sum ^ (16'h0001 << $urandom_range(0, 15));
        frame_bytes.push_back(sum[7:0]);
        frame_bytes.push_back(sum[15:8]);
        if (flavor == FR_TRUNCATED) begin
            k = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > k)
                void'(frame_bytes.pop_back());
        end
        if (flavor == FR_OVERRUN)
            repeat ($urandom_range(1, 4))
                frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic check_output_word(input logic [39:0] data, input logic kind);
        sfc_result_t got;
        frame_word_t want;
        got = data[35:0];
        if (pending_words.size() == 0) begin
            report_mismatch("word with nothing pending", data, '0);
            return;
        end
        want = pending_words.pop_front();
        if (kind !== want.kind)
            report_mismatch("kind", kind, want.kind);
        if (got.payload_byte !== want.word.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.word.payload_byte);
        if (got.status !== want.word.status)
            report_mismatch("status", got.status, want.word.status);
        if (got.send_response !== want.word.send_response)
            report_mismatch("send_response", got.send_response, want.word.send_response);
        if (got.response_byte !== want.word.response_byte)
            report_mismatch("response_byte", got.response_byte, want.word.response_byte);
        if (got.deliver !== want.word.deliver)
            report_mismatch("deliver", got.deliver, want.word.deliver);
        if (got.device_code !== want.word.device_code)
            report_mismatch("device_code", got.device_code, want.word.device_code);
        if (got.payload_length !== want.word.payload_length)
            report_mismatch("payload_length", got.payload_length, want.word.payload_length);
        if (data[39:36] !== 4'h0)
            report_mismatch("pad bits", data[39:36], '0);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_output_word(m_tdata, m_tuser[0]);
    end

    // Sink back-pressure
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
                n = pick_gap(1'b1);
                if (n == 0)
                    n = 1;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Header extremes, short frame, bad marker, payload byte flagged last,
    // bytes past the checksum; first frame runs with the reset value of rx_enable.
    task automatic test_directed_frames();
        src_idle_on = 1'b0;
        frame_bytes = '{8'hFF, 8'h00, MARKER_BYTE, 8'h24, 8'h00};
        send_frame(2'd0, 1'b0);
        frame_bytes = '{8'h00};
        send_frame(2'd1, 1'b0);
        set_rx_enable(1'b1);
        frame_bytes = '{8'h00, 8'h02, MARKER_BYTE, 8'hFF, 8'h00, 8'h25, 8'h01};
        send_frame(2'd3, 1'b0);
        frame_bytes = '{8'h7E, 8'h00, 8'h23, 8'h23, 8'h00};
        send_frame(2'd2, 1'b0);
        frame_bytes = '{8'h02, 8'h03, MARKER_BYTE, 8'hA5};
        send_frame(2'd0, 1'b0);
        frame_bytes = '{8'h02, 8'h00, MARKER_BYTE, 8'h24, 8'h00, 8'h55};
        send_frame(2'd1, 1'b0);
    endtask

    // Largest frame that fits the counter, then one that saturates it.
    task automatic test_long_frames();
        src_idle_on = 1'b1;
        build_frame(250, FR_GOOD);
        send_frame(2'($urandom_range(0, 3)), 1'b0);
        build_frame(253, FR_GOOD);
        send_frame(2'($urandom_range(0, 3)), 1'b0);
    endtask

    task automatic test_rx_enable();
        logic values [3];
        int   i;
        values = '{1'b0, 1'b1, 1'b0};
        for (i = 0; i < 3; i++) begin
            set_rx_enable(values[i]);
            build_frame($urandom_range(0, 6), FR_GOOD);
            send_frame(2'($urandom_range(0, 3)), 1'b0);
        end
    endtask

    task automatic test_random_frames();
        int            phase;
        int            start;
        int            r;
        int            len;
        frame_flavor_t flavor;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0)
                set_rx_enable(1'b1);
            else if (phase == RANDOM_PHASES - 1)
                set_rx_enable(1'b0);
            else
                set_rx_enable(1'($urandom_range(0, 1)));
            src_idle_on    = $urandom_range(0, 3) != 0;
            sink_stalls_on = $urandom_range(0, 3) != 0;
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    flavor = FR_GOOD;
                else if (r < 75)
                    flavor = FR_BAD_SUM;
                else if (r < 80)
                    flavor = FR_BAD_MARKER;
                else if (r < 88)
                    flavor = FR_TRUNCATED;
                else if (r < 94)
                    flavor = FR_OVERRUN;
                else
                    flavor = FR_NOISE;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                build_frame(len, flavor);
                send_frame(2'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    initial begin
        frame_pos    = 8'd0;
        frame_len    = 8'd0;
        frame_sum    = 16'd0;
        marker_ok    = 1'b0;
        chk_lo       = 8'd0;
        rx_en_shadow = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_frames();
        test_long_frames();
        test_rx_enable();
        test_random_frames();

        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
